// ===== sv/ac_address_option_decoder_defines.svh =====
// Assertion macros used by the checker file
`ifndef AC_ADDRESS_OPTION_DECODER_DEFINES_SVH
`define AC_ADDRESS_OPTION_DECODER_DEFINES_SVH
// Assert that a implies b on the same clock edge
`define ACD_ASSERT_IMP(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");
// Assert that a implies b on the next clock edge
`define ACD_ASSERT_NXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");
`endif

// ===== sv/acd_pkg.sv =====
// Package: types, constants and helpers for the controller address decoder
`timescale 1ns / 1ps
package acd_pkg;
  localparam int AcMax       = 16;
  localparam int OptionBytes = 256;
  localparam int ObAw  = $clog2(OptionBytes);
  localparam int CntW  = ObAw + 1;
  localparam int TabAw = $clog2(AcMax);
  localparam int AcCntW = $clog2(AcMax + 1);
  localparam logic [7:0] SubcodeReset = 8'd241;

  localparam logic [1:0] StatusOk       = 2'd0;
  localparam logic [1:0] StatusBadLen   = 2'd1;
  localparam logic [1:0] StatusOverflow = 2'd2;

  localparam logic EntryAddress = 1'b0;
  localparam logic EntrySummary = 1'b1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
    logic       option_form;
    logic       fresh_list;
  } in_word_t;

  typedef struct packed {
    logic        entry_kind;
    logic [31:0] ac_address;
    logic [4:0]  ac_count;
    logic [1:0]  status;
    logic        is_last;
  } out_word_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIR_RD,
    S_SUB_HDR0,
    S_SUB_HDR1,
    S_SUB_CHECK,
    S_SUB_VAL,
    S_RD_WAIT,
    S_FILTER,
    S_DUP,
    S_SUMMARY
  } walk_state_t;

  // Address check: drop zero, loopback, multicast and above
  function automatic logic addr_usable(input logic [31:0] a);
    logic [7:0] top;
    top = a[31:24];
    return !(a == 32'h0000_0000 || a == 32'hFFFF_FFFF || top == 8'd127 || top >= 8'd224);
  endfunction
endpackage

// ===== sv/ac_address_option_decoder.sv =====
// Top level: controller address option decoder
//
//  channel  | handshake          | word
//  in       | start / busy       | in_word  (acd_pkg::in_word_t)
//  out      | result_valid       | result   (acd_pkg::out_word_t)
//  cfg      | cfg_valid/cfg_ready| cfg_data (ac_list_subcode)
//
// A byte that is not last is stored while the block stays idle. The last byte
// starts a walk over the byte store and, per usable candidate address, a
// scan of the address table (one entry per cycle); busy stays high during the
// walk, so no new byte is accepted until the summary is out.
// Reset clears the byte and address counters and sets the subcode register to
// SubcodeReset; the stores hold no reset value. Results come as one-cycle strobes; the receiver cannot stall.
`timescale 1ns / 1ps
module ac_address_option_decoder (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  acd_pkg::in_word_t  in_word,
  output logic               result_valid,
  output acd_pkg::out_word_t result,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [7:0]         cfg_data
);
  import acd_pkg::*;

  walk_state_t state, state_next;
  walk_state_t ret_state;
  logic [CntW-1:0]   bytes_received;
  logic              store_overflowed;
  logic              form_latched;
  logic [AcCntW-1:0] address_count;
  logic [7:0]        subcode;
  logic [CntW-1:0]   pos;        // next byte to read
  logic [CntW-1:0]   val_end;    // end of current sub-option value
  logic [7:0]        sub_code;
  logic [1:0]        bsel;
  logic [31:0]       cand;
  logic [TabAw:0]    dup_idx;
  logic              dup_hit;
  logic              dup_now;
  logic [1:0]        status;

  logic              st_we;
  logic [ObAw-1:0]   st_raddr;
  logic [7:0]        st_rdata;
  logic              tb_we;
  logic [TabAw-1:0]  tb_raddr;
  logic [31:0]       tb_rdata;
  logic              accept;

  assign accept    = start && !busy;
  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign st_we     = accept && (bytes_received < CntW'(OptionBytes));
  assign st_raddr  = pos[ObAw-1:0];
  assign tb_raddr  = dup_idx[TabAw-1:0];
  // Entry dup_idx-1 is on the table read port
  assign dup_now   = (dup_idx != '0) && (tb_rdata == cand);

  acd_byte_store u_store (
    .clk(clk), .we(st_we), .waddr(bytes_received[ObAw-1:0]),
    .wdata(in_word.data_byte), .raddr(st_raddr), .rdata(st_rdata)
  );

  acd_addr_table u_table (
    .clk(clk), .we(tb_we), .waddr(address_count[TabAw-1:0]),
    .wdata(cand), .raddr(tb_raddr), .rdata(tb_rdata)
  );

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && in_word.last_byte) begin
          if (store_overflowed || bytes_received >= CntW'(OptionBytes)) begin
            state_next = S_SUMMARY;
          end else if (!((bytes_received == '0) ? in_word.option_form : form_latched)) begin
            state_next = ((bytes_received + 1'b1) & CntW'(3)) != '0 ? S_SUMMARY : S_DIR_RD;
          end else begin
            state_next = S_SUB_HDR0;
          end
        end
      end
      S_DIR_RD:    state_next = (pos + CntW'(4) <= bytes_received) ? S_RD_WAIT : S_SUMMARY;
      S_SUB_HDR0:  state_next = (pos + CntW'(2) <= bytes_received) ? S_SUB_HDR1 : S_SUMMARY;
      S_SUB_HDR1:  state_next = S_SUB_CHECK;
      S_SUB_CHECK: state_next = ({1'b0, pos} + (CntW+1)'(st_rdata) > {1'b0, bytes_received})
                                ? S_SUMMARY : S_SUB_VAL;
      S_SUB_VAL:   state_next = (pos + CntW'(4) <= val_end && sub_code == subcode)
                                ? S_RD_WAIT : S_SUB_HDR0;
      S_RD_WAIT:   state_next = (bsel == 2'd3) ? S_FILTER : S_RD_WAIT;
      S_FILTER:    state_next = (addr_usable(cand) && address_count < AcCntW'(AcMax))
                                ? S_DUP : ret_state;
      S_DUP:       state_next = (dup_hit || dup_now ||
                                 dup_idx[TabAw:0] == (TabAw+1)'(address_count))
                                ? ret_state : S_DUP;
      S_SUMMARY:   state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  // Table write on a fresh address
  always_comb begin
    tb_we = (state == S_DUP) && !dup_hit && !dup_now &&
            (dup_idx == (TabAw+1)'(address_count));
  end

  // Registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      bytes_received <= '0;
      store_overflowed <= 1'b0;
      form_latched <= 1'b0;
      address_count <= '0;
      subcode <= SubcodeReset;
      result_valid <= 1'b0;
      ret_state <= S_IDLE;
    end else begin
      state <= state_next;
      result_valid <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        subcode <= cfg_data;
      end
      case (state)
        S_IDLE: begin
          pos <= '0;
          status <= StatusOk;
          if (accept) begin
            if (bytes_received == '0) begin
              form_latched <= in_word.option_form;
              if (in_word.fresh_list) begin
                address_count <= '0;
              end
            end
            if (bytes_received < CntW'(OptionBytes)) begin
              bytes_received <= bytes_received + 1'b1;
            end else begin
              store_overflowed <= 1'b1;
            end
            if (in_word.last_byte) begin
              if (store_overflowed || bytes_received >= CntW'(OptionBytes)) begin
                status <= StatusOverflow;
              end else if (!((bytes_received == '0) ? in_word.option_form : form_latched)
                           && (((bytes_received + 1'b1) & CntW'(3)) != '0)) begin
                status <= StatusBadLen;
              end
            end
          end
        end
        S_DIR_RD: begin
          ret_state <= S_DIR_RD;
          bsel <= 2'd0;
          if (pos + CntW'(4) <= bytes_received) pos <= pos + 1'b1;
        end
        S_SUB_HDR0: begin
          // issue code read, then length read
          if (pos + CntW'(2) <= bytes_received) pos <= pos + 1'b1;
        end
        S_SUB_HDR1: begin
          sub_code <= st_rdata;
          pos <= pos + 1'b1;
        end
        S_SUB_CHECK: begin
          val_end <= pos + CntW'(st_rdata);
        end
        S_SUB_VAL: begin
          ret_state <= S_SUB_VAL;
          bsel <= 2'd0;
          if (pos + CntW'(4) <= val_end && sub_code == subcode) begin
            pos <= pos + 1'b1;
          end else begin
            pos <= val_end;
          end
        end
        S_RD_WAIT: begin
          cand <= {cand[23:0], st_rdata};
          bsel <= bsel + 1'b1;
          if (bsel != 2'd3) pos <= pos + 1'b1;
        end
        S_FILTER: begin
          dup_idx <= '0;
          dup_hit <= 1'b0;
        end
        S_DUP: begin
          // table read data is registered, so it lags the index
          if (dup_now) dup_hit <= 1'b1;
          if (!dup_hit && dup_idx != (TabAw+1)'(address_count)) begin
            dup_idx <= dup_idx + 1'b1;
          end
          if (tb_we) begin
            address_count <= address_count + 1'b1;
            result_valid <= 1'b1;
            result.entry_kind <= EntryAddress;
            result.ac_address <= cand;
            result.ac_count <= 5'(address_count + 1'b1);
            result.status <= StatusOk;
            result.is_last <= 1'b0;
          end
        end
        S_SUMMARY: begin
          result_valid <= 1'b1;
          result.entry_kind <= EntrySummary;
          result.ac_address <= '0;
          result.ac_count <= 5'(address_count);
          result.status <= status;
          result.is_last <= 1'b1;
          bytes_received <= '0;
          store_overflowed <= 1'b0;
          form_latched <= 1'b0;
        end
        default: ;
      endcase
    end
  end
endmodule

// ===== sv/acd_byte_store.sv =====
// Byte store: one write port, one registered read port
`timescale 1ns / 1ps
module acd_byte_store (
  input  logic                    clk,
  input  logic                    we,
  input  logic [acd_pkg::ObAw-1:0] waddr,
  input  logic [7:0]              wdata,
  input  logic [acd_pkg::ObAw-1:0] raddr,
  output logic [7:0]              rdata
);
  import acd_pkg::*;
  logic [7:0] mem [OptionBytes];

  // Write, and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== sv/acd_addr_table.sv =====
// Address table: one write port, one registered read port
`timescale 1ns / 1ps
module acd_addr_table (
  input  logic                     clk,
  input  logic                     we,
  input  logic [acd_pkg::TabAw-1:0] waddr,
  input  logic [31:0]              wdata,
  input  logic [acd_pkg::TabAw-1:0] raddr,
  output logic [31:0]              rdata
);
  import acd_pkg::*;
  logic [31:0] mem [AcMax];

  // Write, and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== sv/acd_checker.sv =====
// Port checker for the controller address decoder, bound to the top level
`timescale 1ns / 1ps
`include "ac_address_option_decoder_defines.svh"
module acd_checker (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               result_valid,
  input acd_pkg::out_word_t result
);
  import acd_pkg::*;
  `ACD_ASSERT_IMP(a_sum_addr_zero, clk, rst, result_valid && result.is_last, result.ac_address == 32'h0)
  `ACD_ASSERT_IMP(a_kind_last, clk, rst, result_valid, result.entry_kind == result.is_last)
  `ACD_ASSERT_IMP(a_count_cap, clk, rst, result_valid, result.ac_count <= 5'(AcMax))
  `ACD_ASSERT_IMP(a_idle_at_sum, clk, rst, result_valid && result.is_last, !busy)
  `ACD_ASSERT_NXT(a_quiet_after_accept, clk, rst, start && !busy, !result_valid)
endmodule

bind ac_address_option_decoder acd_checker u_acd_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy),
  .result_valid(result_valid), .result(result)
);
